// File: rtl/dsi_pkg.sv
// types and constants shared by the decimal string parser
// no dependencies
`timescale 1ns / 1ps

package dsi_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int OUT_WIDTH = 64;
  localparam int PROD_WIDTH = VALUE_WIDTH + 4;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_NAN = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    status_t                       status;
    logic signed [OUT_WIDTH-1:0]   parsed_value;
  } out_item_t;

  typedef struct packed {
    phase_t                  phase;
    logic                    is_negative;
    logic [VALUE_WIDTH-1:0]  acc;
    status_t                 err;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_START,
    is_negative: 1'b0,
    acc: '0,
    err: ST_OK
  };

endpackage

// File: rtl/dsi_step.sv
// one parse step: state and one character in, next state and result out
// depends on dsi_pkg
`timescale 1ns / 1ps

module dsi_step
  import dsi_pkg::*;
(
  input  parse_state_t st,
  input  in_item_t     item,
  output parse_state_t st_nxt,
  output out_item_t    result
);

  logic                   digit;
  logic [3:0]             dval;
  logic [PROD_WIDTH-1:0]  prod;
  logic [PROD_WIDTH-1:0]  limit;
  logic [VALUE_WIDTH-1:0] half;
  logic [VALUE_WIDTH-1:0] sval;
  parse_state_t           st_upd;
  phase_t                 ph;
  status_t                status;

  assign digit = item.char_code inside {[CHAR_ZERO:CHAR_NINE]};
  assign dval = digit ? 4'(item.char_code - CHAR_ZERO) : 4'd0;

  // acc * 10 + digit, wide enough to never wrap
  assign prod = PROD_WIDTH'({st.acc, 3'b000}) + PROD_WIDTH'({2'b00, st.acc, 1'b0}) +
                PROD_WIDTH'(dval);

  assign half = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  assign limit = PROD_WIDTH'(half) - PROD_WIDTH'(!st.is_negative);

  always_comb begin
    st_upd = st;
    ph = st.phase;
    if (item.has_char && (st.err == ST_OK)) begin
      if (st.phase == PH_START) begin
        ph = PH_SIGN;
        st_upd.phase = PH_SIGN;
      end
      if ((st.phase == PH_START) && (item.char_code == CHAR_MINUS)) begin
        st_upd.is_negative = 1'b1;
      end else begin
        case (ph)
          PH_SIGN: begin
            if (item.char_code == CHAR_ZERO) begin
              st_upd.phase = PH_ZERO;
            end else if (digit) begin
              st_upd.phase = PH_DIGITS;
              st_upd.acc = VALUE_WIDTH'(dval);
            end else begin
              st_upd.err = ST_NAN;
            end
          end
          PH_ZERO: begin
            st_upd.err = ST_NAN;
          end
          default: begin
            if (!digit) begin
              st_upd.err = ST_NAN;
            end else if (prod > limit) begin
              st_upd.err = ST_OVF;
            end else begin
              st_upd.acc = prod[VALUE_WIDTH-1:0];
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    status = st_upd.err;
    if ((status == ST_OK) && ((st_upd.phase == PH_START) || (st_upd.phase == PH_SIGN))) begin
      status = ST_NAN;
    end
    sval = st_upd.is_negative ? (VALUE_WIDTH'(0) - st_upd.acc) : st_upd.acc;
    result.status = status;
    result.parsed_value = (status == ST_OK) ? OUT_WIDTH'(signed'(sval)) : '0;
    st_nxt = item.is_last ? STATE_RESET : st_upd;
  end

endmodule

// File: rtl/decimal_string_to_signed_int.sv
// top level of the streaming decimal string to signed integer parser
// depends on dsi_pkg and dsi_step
//
//   channel | direction | ports                          | payload
//   in      | input     | in_valid, in_stall, in_data    | in_item_t
//   out     | output    | out_valid, out_stall, out_data | out_item_t
//
// one character transaction is taken every cycle while in_stall is low; throughput is set by the
// combinational multiply-by-ten and limit compare in dsi_step
// a result is loaded into the output register when its last character advances out of the input register
// synchronous active-low reset returns the parse state to start, no error
// out_stall holds the result register and backs up into in_stall only when a
// last character is waiting behind a result that has not been taken
`timescale 1ns / 1ps

module decimal_string_to_signed_int
  import dsi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic         in_valid_r;
  in_item_t     in_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  out_item_t    result;
  logic         out_valid_r;
  out_item_t    out_r;
  logic         adv;

  dsi_step u_step (
    .st     (st_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .result (result)
  );

  assign adv = in_valid_r && (!in_r.is_last || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r <= STATE_RESET;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        st_r <= st_nxt;
      end
      if (adv && in_r.is_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
    if (adv && in_r.is_last) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_acc_only_in_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.acc != '0) |-> (st_r.phase == PH_DIGITS))
    else $error("accumulator nonzero outside digit phase");

  a_err_after_char: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.err != ST_OK) |-> (st_r.phase != PH_START))
    else $error("error recorded while still at start");

  a_fail_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |-> (out_r.parsed_value == '0))
    else $error("failed parse carries nonzero value");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_r.is_last) |=>
      ((st_r.phase == PH_START) && (st_r.acc == '0) && (st_r.err == ST_OK) &&
       !st_r.is_negative && out_valid_r))
    else $error("state not restarted after last character");

endmodule

// File: sim/dsi_tb_pkg.sv
// scoreboard for the decimal string parser: predicts status and value per string
// depends on dsi_pkg for the transaction types and character constants
`timescale 1ns / 1ps

package dsi_tb_pkg;

  import dsi_pkg::*;

  class atoi_scoreboard;

    phase_t                 phase;
    bit                     negative;
    logic [VALUE_WIDTH-1:0] magnitude;
    status_t                err;
    out_item_t              expected_results[$];
    int unsigned            mismatches;

    function new();
      clear_parse();
      mismatches = 0;
    endfunction

    function void clear_parse();
      phase = PH_START;
      negative = 1'b0;
      magnitude = '0;
      err = ST_OK;
    endfunction

    function void take_char(logic [7:0] c);
      bit                     digit;
      logic [VALUE_WIDTH-1:0] d;
      logic [VALUE_WIDTH-1:0] limit;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d = digit ? VALUE_WIDTH'(c - CHAR_ZERO) : '0;
      if (err != ST_OK) return;
      if (phase == PH_START) begin
        phase = PH_SIGN;
        if (c == CHAR_MINUS) begin
          negative = 1'b1;
          return;
        end
      end
      limit = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      if (!negative) limit = limit - 1'b1;
      case (phase)
        PH_SIGN: begin
          if (c == CHAR_ZERO) begin
            phase = PH_ZERO;
          end else if (digit) begin
            phase = PH_DIGITS;
            magnitude = d;
          end else begin
            err = ST_NAN;
          end
        end
        PH_ZERO: err = ST_NAN;
        default: begin
          if (!digit) begin
            err = ST_NAN;
          end else if (magnitude > (limit - d) / 10) begin
            err = ST_OVF;
          end else begin
            magnitude = magnitude * 10 + d;
          end
        end
      endcase
    endfunction

    // called for every accepted input transaction
    function void note_input(in_item_t it);
      out_item_t res;
      if (it.has_char) take_char(it.char_code);
      if (!it.is_last) return;
      res.status = err;
      if (err == ST_OK && (phase == PH_START || phase == PH_SIGN)) res.status = ST_NAN;
      res.parsed_value = '0;
      if (res.status == ST_OK) begin
        res.parsed_value = OUT_WIDTH'(signed'(negative ? (VALUE_WIDTH'(0) - magnitude)
                                                       : magnitude));
      end
      expected_results = {expected_results, res};
      clear_parse();
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, parsed_value %0d",
               got.status, got.parsed_value);
        mismatches++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, got.status);
        mismatches++;
      end
      if (got.parsed_value !== exp_res.parsed_value) begin
        $error("parsed_value: expected %0d, actual %0d",
               exp_res.parsed_value, got.parsed_value);
        mismatches++;
      end
    endfunction

  endclass

endpackage

// File: sim/tb_decimal_string_to_signed_int.sv
// testbench top for decimal_string_to_signed_int: directed and random strings
// depends on dsi_pkg, dsi_tb_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_decimal_string_to_signed_int
  import dsi_pkg::*, dsi_tb_pkg::*;
();

  localparam int unsigned STRING_ITEMS = 450;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [63:0] MIN_MAGNITUDE = 64'h8000_0000_0000_0000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic        quiet = 1'b0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit          drained = 1'b0;
  in_item_t    str_q[$];

  atoi_scoreboard sb = new();

  always #2 clk = ~clk;

  decimal_string_to_signed_int dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= !quiet && ($urandom_range(99) < 9);
  end

  task automatic drive(in_item_t it);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  function automatic void put_char(logic [7:0] c);
    in_item_t it;
    it.char_code = c;
    it.has_char = 1'b1;
    it.is_last = 1'b0;
    str_q = {str_q, it};
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void put_digits(int unsigned len);
    put_char(CHAR_ONE + 8'($urandom_range(8)));
    for (int unsigned i = 1; i < len; i++) put_char(CHAR_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void put_number(logic [63:0] mag);
    logic [7:0] digs[$];
    do begin
      digs.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    foreach (digs[i]) put_char(digs[i]);
  endfunction

  // transaction that carries no character and does not end the string
  function automatic in_item_t skip_item();
    in_item_t it;
    it.char_code = 8'($urandom_range(255));
    it.has_char = 1'b0;
    it.is_last = 1'b0;
    return it;
  endfunction

  task automatic close_and_send(bit marker);
    in_item_t it;
    if (marker || str_q.size() == 0) begin
      it.char_code = 8'($urandom_range(255));
      it.has_char = 1'b0;
      it.is_last = 1'b1;
    end else begin
      it = str_q.pop_back();
      it.is_last = 1'b1;
    end
    str_q = {str_q, it};
    foreach (str_q[i]) begin
      if ($urandom_range(99) < 8) drive(skip_item());
      drive(str_q[i]);
      if (str_q[i].has_char || str_q[i].is_last) items_sent++;
    end
    str_q.delete();
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void random_string();
    int unsigned k;
    int unsigned idx;
    bit          neg;
    logic [63:0] mag;
    in_item_t    it;
    k = $urandom_range(99);
    if (k < 50) begin
      if ($urandom_range(1)) put_char(CHAR_MINUS);
      if ($urandom_range(9) == 0) begin
        put_char(CHAR_ZERO);
      end else begin
        put_digits(($urandom_range(3) == 0) ? $urandom_range(19, 10) : $urandom_range(6, 1));
      end
    end else if (k < 65) begin
      // values around the edges of the signed range
      neg = 1'($urandom_range(1));
      if (neg) put_char(CHAR_MINUS);
      if ($urandom_range(4) == 0) begin
        mag = {$urandom, $urandom};
      end else begin
        mag = MIN_MAGNITUDE - (neg ? 64'd0 : 64'd1) + 64'($urandom_range(6)) - 64'd3;
      end
      put_number(mag);
      if ($urandom_range(9) == 0) put_char(CHAR_ZERO + 8'($urandom_range(9)));
    end else if (k < 85) begin
      case ($urandom_range(3))
        0: begin
          if ($urandom_range(1)) put_char(CHAR_MINUS);
          put_char(CHAR_ZERO);
          put_digits($urandom_range(4, 1));
        end
        1: begin
          put_char(CHAR_MINUS);
          put_char(CHAR_MINUS);
          put_digits($urandom_range(4, 1));
        end
        2: begin
          put_digits($urandom_range(6, 1));
          idx = $urandom_range(str_q.size() - 1);
          it = str_q[idx];
          case ($urandom_range(4))
            0: it.char_code = CHAR_ZERO - 8'd1;
            1: it.char_code = CHAR_NINE + 8'd1;
            2: it.char_code = CHAR_MINUS;
            3: it.char_code = 8'h20;
            default: it.char_code = 8'($urandom_range(255));
          endcase
          str_q[idx] = it;
        end
        default: begin
          put_char(CHAR_MINUS);
          put_digits($urandom_range(3, 1));
          put_char(CHAR_MINUS);
        end
      endcase
    end else begin
      repeat ($urandom_range(5)) put_char(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_text("0");   close_and_send(1'b0);
    put_text("-0");  close_and_send(1'b0);
    put_text("-");   close_and_send(1'b0);
    close_and_send(1'b1);
    put_text("05");  close_and_send(1'b0);
    put_text("--1"); close_and_send(1'b0);
    put_text("7:");  close_and_send(1'b0);
    put_text("8/");  close_and_send(1'b0);
    put_char(8'hff); close_and_send(1'b0);
    put_text("-9");  close_and_send(1'b0);
    put_text("1");
    str_q = {str_q, skip_item()};
    put_text("2");
    close_and_send(1'b1);
    wait_drain();

    while (items_sent < STRING_ITEMS) begin
      quiet <= (items_sent >= 150) && (items_sent < 260);
      if (!drained && items_sent >= 300) begin
        wait_drain();
        drained = 1'b1;
      end
      random_string();
      close_and_send($urandom_range(3) == 0);
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
